// ===== rtl/drs_pkg.sv =====
// shared types and constants for the disk request scheduler
`default_nettype none
package drs_pkg;
	localparam int QUEUE_DEPTH_DEF = 32;
	localparam int TRACK_BITS_DEF  = 16;
	localparam int OUT_BITS        = 16;

	localparam logic [2:0] MODE_FIFO  = 3'd0;
	localparam logic [2:0] MODE_SSTF  = 3'd1;
	localparam logic [2:0] MODE_LOOK  = 3'd2;
	localparam logic [2:0] MODE_CLOOK = 3'd3;
	localparam logic [2:0] MODE_FSCAN = 3'd4;

	localparam logic CMD_ADD  = 1'b0;
	localparam logic CMD_PICK = 1'b1;

	localparam logic [1:0] ST_ADDED   = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_PICKED  = 2'd2;
	localparam logic [1:0] ST_NONE    = 2'd3;

	// scan rules
	localparam logic [1:0] HOW_UP   = 2'd0;
	localparam logic [1:0] HOW_DOWN = 2'd1;
	localparam logic [1:0] HOW_LOW  = 2'd2;
	localparam logic [1:0] HOW_NEAR = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SWAP,
		S_SCAN,
		S_JUDGE,
		S_REMOVE,
		S_DONE
	} state_t;

	// per-cycle command to the row of cells
	typedef struct packed {
		logic append_act;
		logic append_pnd;
		logic swap;
		logic rotate;
		logic remove;
	} cell_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/drs_cell.sv =====
// one queue slot: active and pending entries; active ones shift to the row head
`default_nettype none
module drs_cell #(
	parameter int TRACK_BITS = drs_pkg::TRACK_BITS_DEF
) (
	input  wire                     clk,
	input  drs_pkg::cell_ctl_t      ctl,
	input  wire                     sel_append_act,
	input  wire                     sel_append_pnd,
	input  wire                     sel_shift,
	input  wire  [TRACK_BITS-1:0]   new_track,
	input  wire  [TRACK_BITS-1:0]   next_act,
	output logic [TRACK_BITS-1:0]   act_q,
	output logic [TRACK_BITS-1:0]   pnd_q
);
	import drs_pkg::*;

	always_ff @(posedge clk) begin
		if (ctl.swap) begin
			act_q <= pnd_q;
		end else if (ctl.rotate) begin
			act_q <= next_act;
		end else if (ctl.remove && sel_shift) begin
			act_q <= next_act;
		end else if (ctl.append_act && sel_append_act) begin
			act_q <= new_track;
		end
		if (ctl.append_pnd && sel_append_pnd) begin
			pnd_q <= new_track;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/drs_scan.sv =====
// serial selection of the best entry as the row rotates past slot zero
`default_nettype none
module drs_scan #(
	parameter int TRACK_BITS = drs_pkg::TRACK_BITS_DEF,
	parameter int IDX_BITS   = 5
) (
	input  wire                   clk,
	input  wire                   clear,
	input  wire                   step,
	input  wire  [1:0]            how,
	input  wire  [TRACK_BITS-1:0] head,
	input  wire  [TRACK_BITS-1:0] track,
	input  wire  [IDX_BITS-1:0]   idx,
	output logic                  found_q,
	output logic [IDX_BITS-1:0]   best_idx_q
);
	import drs_pkg::*;

	logic [TRACK_BITS-1:0] key;
	logic                  elig;
	logic [TRACK_BITS-1:0] best_key_q;

	always_comb begin
		elig = 1'b1;
		key  = track;
		case (how)
			HOW_UP: begin
				elig = track >= head;
				key  = track - head;
			end
			HOW_DOWN: begin
				elig = track <= head;
				key  = head - track;
			end
			HOW_LOW: key = track;
			default: key = (track >= head) ? track - head : head - track;
		endcase
	end

	always_ff @(posedge clk) begin
		if (clear) begin
			found_q <= 1'b0;
		end else if (step && elig && (!found_q || key < best_key_q)) begin
			found_q    <= 1'b1;
			best_key_q <= key;
			best_idx_q <= idx;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/disk_request_scheduler_top.sv =====
// top level of the disk request scheduler
//
// usage: drive cmd and request_track with start high while busy is low; the
// transaction is taken at that edge. one result appears later with done high
// for exactly one cycle, carrying status, picked_track and seek_distance.
// policy_mode (mode_q) is written through cfg_we / cfg_wdata; the user must
// write it only while idle, the block itself does not enforce this. the queue
// is a row of QUEUE_DEPTH cells; the active queue rotates through slot zero
// so the scan unit sees one entry per cycle, and each scan pass rotates the
// whole row once so it ends in its original order. an add passes through the
// swap and done states; a fifo pick through swap, remove and done; a scanning
// pick through swap, scan and judge, a second scan and judge when look, fscan
// or circular look finds nothing, then remove and done; an empty active queue
// adds a swap state that swaps in the pending queue. busy drops in the cycle
// after the result. the scan rotation over the cell row sets the pick time.
// reset clears counts, head, sweep direction and mode; the cell contents stay
// undefined until written. results cannot be stalled by the receiver.
`default_nettype none
module disk_request_scheduler_top #(
	parameter int QUEUE_DEPTH = drs_pkg::QUEUE_DEPTH_DEF,
	parameter int TRACK_BITS  = drs_pkg::TRACK_BITS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire         cmd,
	input  wire  [15:0] request_track,
	input  wire         cfg_we,
	input  wire  [2:0]  cfg_wdata,
	output logic        done,
	output logic [1:0]  status,
	output logic [15:0] picked_track,
	output logic [15:0] seek_distance
);
	import drs_pkg::*;

	localparam int IB = $clog2(QUEUE_DEPTH);
	localparam int CB = $clog2(QUEUE_DEPTH + 1);

	state_t state_q, state_d;
	logic [2:0]            mode_q;
	logic [CB-1:0]         act_cnt_q, pnd_cnt_q;
	logic [TRACK_BITS-1:0] head_q;
	logic                  down_q;
	logic                  cmd_q;
	logic [TRACK_BITS-1:0] trk_q;
	logic [IB-1:0]         cnt_q;
	logic                  second_q;
	logic [1:0]            how_q;
	logic [IB-1:0]         sel_q;

	cell_ctl_t             ctl;
	logic [TRACK_BITS-1:0] act_v [QUEUE_DEPTH];
	logic [TRACK_BITS-1:0] pnd_v [QUEUE_DEPTH];

	logic                  sc_clear, sc_step, sc_found;
	logic [IB-1:0]         sc_idx;

	genvar g;
	generate
		for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
			logic [TRACK_BITS-1:0] nxt;
			logic                  shf;
			if (g == QUEUE_DEPTH - 1) begin : g_last
				assign nxt = act_v[0];
			end else begin : g_mid
				assign nxt = act_v[g+1];
			end
			assign shf = IB'(g) >= sel_q;
			drs_cell #(.TRACK_BITS(TRACK_BITS)) u_cell (
				.clk            (clk),
				.ctl            (ctl),
				.sel_append_act (act_cnt_q[IB-1:0] == IB'(g)),
				.sel_append_pnd (pnd_cnt_q[IB-1:0] == IB'(g)),
				.sel_shift      (shf),
				.new_track      (trk_q),
				.next_act       (nxt),
				.act_q          (act_v[g]),
				.pnd_q          (pnd_v[g])
			);
		end
	endgenerate

	// cnt_q is the index of the entry at slot zero while rotating
	drs_scan #(.TRACK_BITS(TRACK_BITS), .IDX_BITS(IB)) u_scan (
		.clk        (clk),
		.clear      (sc_clear),
		.step       (sc_step),
		.how        (how_q),
		.head       (head_q),
		.track      (act_v[0]),
		.idx        (cnt_q),
		.found_q    (sc_found),
		.best_idx_q (sc_idx)
	);

	logic full_add;
	logic use_pnd;
	assign use_pnd  = mode_q == MODE_FSCAN;
	assign full_add = use_pnd ? (pnd_cnt_q == CB'(QUEUE_DEPTH))
	                          : (act_cnt_q == CB'(QUEUE_DEPTH));

	logic look_mode;
	assign look_mode = mode_q == MODE_LOOK || mode_q == MODE_FSCAN;
	logic scan_mode;
	assign scan_mode = look_mode || mode_q == MODE_SSTF || mode_q == MODE_CLOOK;
	logic scan_last;
	assign scan_last = cnt_q == IB'(QUEUE_DEPTH - 1);
	logic in_row;
	assign in_row = CB'(cnt_q) < act_cnt_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (start) state_d = S_SWAP;
			S_SWAP: begin
				if (cmd_q == CMD_ADD) state_d = S_DONE;
				else if (act_cnt_q == '0 && pnd_cnt_q == '0) state_d = S_DONE;
				else if (act_cnt_q == '0) state_d = S_SWAP;
				else if (scan_mode) state_d = S_SCAN;
				else state_d = S_REMOVE;
			end
			S_SCAN: if (scan_last) state_d = S_JUDGE;
			S_JUDGE: state_d = (sc_found || second_q) ? S_REMOVE : S_SCAN;
			S_REMOVE: state_d = S_DONE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs to cells and scan unit
	always_comb begin
		ctl      = '0;
		sc_clear = 1'b0;
		sc_step  = 1'b0;
		busy     = state_q != S_IDLE;
		case (state_q)
			S_SWAP: begin
				if (cmd_q == CMD_ADD) begin
					ctl.append_act = !full_add && !use_pnd;
					ctl.append_pnd = !full_add && use_pnd;
				end else if (act_cnt_q == '0 && pnd_cnt_q != '0) begin
					ctl.swap = 1'b1;
				end
				sc_clear = 1'b1;
			end
			S_SCAN: begin
				ctl.rotate = 1'b1;
				sc_step    = in_row;
			end
			S_JUDGE: sc_clear = 1'b1;
			S_REMOVE: ctl.remove = 1'b1;
			default: ;
		endcase
	end

	logic [TRACK_BITS-1:0] pick_t;
	assign pick_t = act_v[sel_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			mode_q        <= MODE_FIFO;
			act_cnt_q     <= '0;
			pnd_cnt_q     <= '0;
			head_q        <= '0;
			down_q        <= 1'b0;
			done          <= 1'b0;
			status        <= ST_ADDED;
			picked_track  <= '0;
			seek_distance <= '0;
			cmd_q         <= CMD_ADD;
			trk_q         <= '0;
			cnt_q         <= '0;
			second_q      <= 1'b0;
			how_q         <= HOW_UP;
			sel_q         <= '0;
		end else begin
			state_q <= state_d;
			done    <= 1'b0;
			if (cfg_we) mode_q <= cfg_wdata;
			case (state_q)
				S_IDLE: if (start) begin
					cmd_q <= cmd;
					trk_q <= TRACK_BITS'(request_track);
				end
				S_SWAP: begin
					cnt_q    <= '0;
					second_q <= 1'b0;
					sel_q    <= '0;
					if (cmd_q == CMD_ADD) begin
						done          <= 1'b1;
						status        <= full_add ? ST_FULL : ST_ADDED;
						picked_track  <= '0;
						seek_distance <= '0;
						if (!full_add && use_pnd)  pnd_cnt_q <= pnd_cnt_q + 1'b1;
						if (!full_add && !use_pnd) act_cnt_q <= act_cnt_q + 1'b1;
					end else if (act_cnt_q == '0 && pnd_cnt_q == '0) begin
						done          <= 1'b1;
						status        <= ST_NONE;
						picked_track  <= '0;
						seek_distance <= '0;
					end else if (act_cnt_q == '0) begin
						act_cnt_q <= pnd_cnt_q;
						pnd_cnt_q <= '0;
						if (use_pnd) down_q <= 1'b0;
					end else begin
						case (mode_q)
							MODE_SSTF:  how_q <= HOW_NEAR;
							MODE_CLOOK: how_q <= HOW_UP;
							MODE_LOOK, MODE_FSCAN: how_q <= down_q ? HOW_DOWN : HOW_UP;
							default:    how_q <= HOW_UP;
						endcase
					end
				end
				S_SCAN: begin
					if (scan_last) cnt_q <= '0;
					else cnt_q <= cnt_q + 1'b1;
				end
				S_JUDGE: begin
					if (sc_found || second_q) begin
						sel_q <= sc_found ? sc_idx : '0;
					end else begin
						second_q <= 1'b1;
						if (mode_q == MODE_CLOOK) how_q <= HOW_LOW;
						else begin
							how_q  <= (how_q == HOW_UP) ? HOW_DOWN : HOW_UP;
							down_q <= how_q == HOW_UP;
						end
					end
				end
				S_REMOVE: begin
					done          <= 1'b1;
					status        <= ST_PICKED;
					picked_track  <= OUT_BITS'(pick_t);
					seek_distance <= OUT_BITS'((pick_t >= head_q) ?
					                 pick_t - head_q : head_q - pick_t);
					head_q        <= pick_t;
					act_cnt_q     <= act_cnt_q - 1'b1;
					if (use_pnd && act_cnt_q == CB'(1)) down_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== tb/disk_request_scheduler_top_tb.sv =====
// self-checking testbench for the disk request scheduler: random and directed adds and picks in all modes
`timescale 1ns / 100ps
`default_nettype none
module disk_request_scheduler_top_tb;
	import drs_pkg::*;

	localparam int DEPTH = QUEUE_DEPTH_DEF;

	typedef struct packed {
		logic        op;
		logic [15:0] track;
	} sched_req_t;

	typedef struct packed {
		logic [1:0]  st;
		logic [15:0] trk;
		logic [15:0] seek;
	} sched_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        cmd = 1'b0;
	logic [15:0] request_track = '0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_wdata = '0;
	wire         busy, done;
	wire  [1:0]  status;
	wire  [15:0] picked_track, seek_distance;

	disk_request_scheduler_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.request_track(request_track), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.done(done), .status(status), .picked_track(picked_track),
		.seek_distance(seek_distance)
	);

	// predictor state
	logic [15:0] act_q[$];
	logic [15:0] pnd_q[$];
	logic [15:0] head_pos;
	logic        going_down;
	logic [2:0]  cur_mode;

	sched_req_t  req_pending[$];
	sched_res_t  expected_results[$];
	int          errors = 0;
	int          results_seen = 0;
	int          items_sent = 0;
	int          sender_idle_pct = 0;
	longint      cycle_count = 0;
	logic        in_taken = 1'b0;

	// which: 0 at/above head, 1 at/below head, 2 lowest track
	function automatic int best_index(int which);
		int          sel;
		logic [16:0] key, best_key;
		sel = -1;
		best_key = '0;
		for (int i = 0; i < act_q.size(); i++) begin
			if (which == 0) begin
				if (act_q[i] < head_pos) continue;
				key = act_q[i] - head_pos;
			end else if (which == 1) begin
				if (act_q[i] > head_pos) continue;
				key = head_pos - act_q[i];
			end else begin
				key = act_q[i];
			end
			if (sel < 0 || key < best_key) begin
				sel = i;
				best_key = key;
			end
		end
		return sel;
	endfunction

	function automatic int look_index();
		int sel;
		if (!going_down) begin
			sel = best_index(0);
			if (sel < 0) begin
				sel = best_index(1);
				going_down = 1'b1;
			end
		end else begin
			sel = best_index(1);
			if (sel < 0) begin
				sel = best_index(0);
				going_down = 1'b0;
			end
		end
		return sel;
	endfunction

	function automatic sched_res_t predict_schedule(sched_req_t r);
		sched_res_t  res;
		int          sel;
		logic [15:0] t;
		logic [16:0] d, bd;
		res = '0;
		if (r.op == CMD_ADD) begin
			res.st = ST_ADDED;
			if (cur_mode == MODE_FSCAN) begin
				if (pnd_q.size() >= DEPTH) res.st = ST_FULL;
				else pnd_q.insert(pnd_q.size(), r.track);
			end else begin
				if (act_q.size() >= DEPTH) res.st = ST_FULL;
				else act_q.insert(act_q.size(), r.track);
			end
			return res;
		end
		if (act_q.size() == 0) begin
			if (pnd_q.size() == 0) begin
				res.st = ST_NONE;
				return res;
			end
			act_q = pnd_q;
			pnd_q = {};
			if (cur_mode == MODE_FSCAN) going_down = 1'b0;
		end
		sel = 0;
		case (cur_mode)
			MODE_SSTF: begin
				bd = '0;
				sel = -1;
				for (int i = 0; i < act_q.size(); i++) begin
					d = (act_q[i] >= head_pos) ? act_q[i] - head_pos : head_pos - act_q[i];
					if (sel < 0 || d < bd) begin
						sel = i;
						bd = d;
					end
				end
			end
			MODE_LOOK, MODE_FSCAN: sel = look_index();
			MODE_CLOOK: begin
				sel = best_index(0);
				if (sel < 0) sel = best_index(2);
			end
			default: sel = 0;
		endcase
		if (sel < 0) sel = 0;
		t = act_q[sel];
		act_q.delete(sel);
		res.st = ST_PICKED;
		res.trk = t;
		res.seek = (t >= head_pos) ? t - head_pos : head_pos - t;
		head_pos = t;
		if (cur_mode == MODE_FSCAN && act_q.size() == 0) going_down = 1'b0;
		return res;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
			cycle_count);
		errors++;
	endtask

	initial begin
		forever #4 clk = ~clk;
	end

	// acceptance of the transaction on the input ports
	always @(posedge clk) begin
		in_taken <= arst_n && start && !busy;
	end

	// driver
	always @(negedge clk) begin
		if (arst_n && (!start || in_taken)) begin
			if (req_pending.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
				sched_req_t r;
				r = req_pending[0];
				req_pending.delete(0);
				expected_results.insert(expected_results.size(), predict_schedule(r));
				cmd <= r.op;
				request_track <= r.track;
				start <= 1'b1;
				items_sent++;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (done) begin
			results_seen <= results_seen + 1;
			if (expected_results.size() == 0) begin
				$display("unexpected transaction at cycle %0d", cycle_count);
				errors++;
			end else begin
				sched_res_t e;
				e = expected_results[0];
				expected_results.delete(0);
				if (status !== e.st) report_mismatch("status", status, e.st);
				if (picked_track !== e.trk) report_mismatch("picked_track", picked_track, e.trk);
				if (seek_distance !== e.seek)
					report_mismatch("seek_distance", seek_distance, e.seek);
			end
		end
		if (cycle_count > 1500000) begin
			$display("timeout at cycle %0d", cycle_count);
			$display("disk_request_scheduler_top_tb: FAIL");
			$finish;
		end
	end

	task automatic push_req(logic op, logic [15:0] trk);
		sched_req_t r;
		r.op = op;
		r.track = trk;
		req_pending.insert(req_pending.size(), r);
	endtask

	task automatic drain();
		while (req_pending.size() > 0 || expected_results.size() > 0 || start)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic set_mode(logic [2:0] m);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		cur_mode = m;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// half the time a cluster of tracks so ties and sweeps happen, else anywhere or an extreme
	function automatic logic [15:0] rand_track(logic [15:0] base);
		case ($urandom_range(3))
			0: return 16'($urandom_range(16'hffff));
			1: return ($urandom_range(1)) ? 16'hffff : 16'h0000;
			default: return 16'(base + $urandom_range(40));
		endcase
	endfunction

	initial begin
		logic [15:0] base;
		int          n, fill;
		head_pos = '0;
		going_down = 1'b0;
		cur_mode = MODE_FIFO;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty pick, extremes, full queue, ties, then each mode
		push_req(CMD_PICK, 16'h0);
		push_req(CMD_ADD, 16'hffff);
		push_req(CMD_ADD, 16'h0000);
		push_req(CMD_ADD, 16'h5555);
		push_req(CMD_ADD, 16'haaaa);
		for (int i = 0; i < 5; i++) push_req(CMD_PICK, 16'($urandom));
		drain();
		for (int i = 0; i < DEPTH + 2; i++) push_req(CMD_ADD, 16'h100);
		for (int i = 0; i < DEPTH + 1; i++) push_req(CMD_PICK, 16'hffff);
		drain();

		for (int ph = 0; ph < 16; ph++) begin
			case (ph % 4)
				0: sender_idle_pct = 0;
				1: sender_idle_pct = 61;
				2: sender_idle_pct = 0;
				default: sender_idle_pct = 7;
			endcase
			set_mode((ph < 8) ? ph[2:0] : 3'($urandom_range(4)));
			base = 16'($urandom);
			fill = $urandom_range(1, 4) * 10;
			n = 0;
			while (n < 72) begin
				// fill burst then drain burst, with random mix
				int burst;
				burst = $urandom_range(1, fill);
				for (int k = 0; k < burst; k++) begin
					push_req(($urandom_range(9) < 7) ? CMD_ADD : CMD_PICK, rand_track(base));
					n++;
				end
				burst = $urandom_range(1, fill);
				for (int k = 0; k < burst; k++) begin
					push_req(($urandom_range(9) < 2) ? CMD_ADD : CMD_PICK, rand_track(base));
					n++;
				end
			end
			drain();
		end
		set_mode(MODE_FIFO);
		for (int i = 0; i < DEPTH + 1; i++) push_req(CMD_PICK, 16'h0);
		drain();

		$display("sent %0d transactions, checked %0d results over all five modes and unused codes",
			items_sent, results_seen);
		if (errors == 0)
			$display("disk_request_scheduler_top_tb: PASS");
		else
			$display("disk_request_scheduler_top_tb: FAIL");
		$finish;
	end
endmodule
`default_nettype wire

// ===== disk_request_scheduler_top.f =====
rtl/drs_pkg.sv
rtl/drs_cell.sv
rtl/drs_scan.sv
rtl/disk_request_scheduler_top.sv
tb/disk_request_scheduler_top_tb.sv
